@@ design/blt_pkg.sv @@
// ----------------------------------------------------------------------------
// blt_pkg: shared definitions of the BASIC line tokenizer
// Token kind codes, character constants, the keyword table, and the
// structs that carry a classified byte and a result item.
// ----------------------------------------------------------------------------
package blt_pkg;

   localparam int MAX_IDENT_CHARS  = 31;
   localparam int MAX_STRING_CHARS = 255;

   localparam int IDENT_LEN_W = $clog2(MAX_IDENT_CHARS + 1);
   localparam int IDENT_IDX_W = $clog2(MAX_IDENT_CHARS);
   localparam int STR_LEN_W   = $clog2(MAX_STRING_CHARS + 1);

   localparam int KEYWORD_COUNT = 18;
   localparam int KW_CHARS      = 8;
   localparam int KIND_W        = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   localparam logic [KIND_W-1:0] KIND_END     = 6'd0;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd1;
   localparam logic [KIND_W-1:0] KIND_STRING  = 6'd2;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd3;
   localparam logic [KIND_W-1:0] KIND_LET     = 6'd4;
   localparam logic [KIND_W-1:0] KIND_PRINT   = 6'd5;
   localparam logic [KIND_W-1:0] KIND_INPUT   = 6'd6;
   localparam logic [KIND_W-1:0] KIND_IF      = 6'd7;
   localparam logic [KIND_W-1:0] KIND_THEN    = 6'd8;
   localparam logic [KIND_W-1:0] KIND_GOTO    = 6'd9;
   localparam logic [KIND_W-1:0] KIND_GOSUB   = 6'd10;
   localparam logic [KIND_W-1:0] KIND_RETURN  = 6'd11;
   localparam logic [KIND_W-1:0] KIND_FOR     = 6'd12;
   localparam logic [KIND_W-1:0] KIND_TO      = 6'd13;
   localparam logic [KIND_W-1:0] KIND_STEP    = 6'd14;
   localparam logic [KIND_W-1:0] KIND_NEXT    = 6'd15;
   localparam logic [KIND_W-1:0] KIND_REM     = 6'd16;
   localparam logic [KIND_W-1:0] KIND_KW_END  = 6'd17;
   localparam logic [KIND_W-1:0] KIND_CLS     = 6'd18;
   localparam logic [KIND_W-1:0] KIND_CIRCLE  = 6'd19;
   localparam logic [KIND_W-1:0] KIND_WAIT    = 6'd20;
   localparam logic [KIND_W-1:0] KIND_PRESENT = 6'd21;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd22;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd23;
   localparam logic [KIND_W-1:0] KIND_STAR    = 6'd24;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd25;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd26;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd27;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd28;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd29;
   localparam logic [KIND_W-1:0] KIND_EQUAL   = 6'd30;
   localparam logic [KIND_W-1:0] KIND_LT      = 6'd31;
   localparam logic [KIND_W-1:0] KIND_LE      = 6'd32;
   localparam logic [KIND_W-1:0] KIND_NE      = 6'd33;
   localparam logic [KIND_W-1:0] KIND_GT      = 6'd34;
   localparam logic [KIND_W-1:0] KIND_GE      = 6'd35;

   // One source byte after classification.
   typedef struct packed {
      logic [7:0]        byte_val;
      logic [7:0]        upper;
      logic [3:0]        digit;
      logic              is_digit;
      logic              is_alpha;
      logic              is_identc;
      logic              is_quote;
      logic              is_eol;
      logic              is_lt;
      logic              is_gt;
      logic              is_eq;
      logic              idle_emit;
      logic [KIND_W-1:0] idle_kind;
   } blt_class_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [31:0]       number_value;
      logic [7:0]        text_char;
      logic              text_valid;
      logic              token_end;
      logic              last;
   } blt_result_type;

   // Keyword text, first character in the top byte, zero padded.
   function automatic logic [63:0] kw_word(input logic [KIND_W-1:0] kind);
      logic [63:0] w;
      w = '0;
      unique case (kind)
         KIND_LET:     w = {"LET", 40'h0};
         KIND_PRINT:   w = {"PRINT", 24'h0};
         KIND_INPUT:   w = {"INPUT", 24'h0};
         KIND_IF:      w = {"IF", 48'h0};
         KIND_THEN:    w = {"THEN", 32'h0};
         KIND_GOTO:    w = {"GOTO", 32'h0};
         KIND_GOSUB:   w = {"GOSUB", 24'h0};
         KIND_RETURN:  w = {"RETURN", 16'h0};
         KIND_FOR:     w = {"FOR", 40'h0};
         KIND_TO:      w = {"TO", 48'h0};
         KIND_STEP:    w = {"STEP", 32'h0};
         KIND_NEXT:    w = {"NEXT", 32'h0};
         KIND_REM:     w = {"REM", 40'h0};
         KIND_KW_END:  w = {"END", 40'h0};
         KIND_CLS:     w = {"CLS", 40'h0};
         KIND_CIRCLE:  w = {"CIRCLE", 16'h0};
         KIND_WAIT:    w = {"WAIT", 32'h0};
         KIND_PRESENT: w = {"PRESENT", 8'h0};
         default:      w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] kw_char(input logic [KIND_W-1:0] kind,
                                          input logic [2:0] pos);
      logic [63:0] w;
      w = kw_word(kind);
      return w[8 * (7 - int'(pos)) +: 8];
   endfunction

   function automatic logic [3:0] kw_len(input logic [KIND_W-1:0] kind);
      logic [63:0] w;
      logic [3:0]  n;
      w = kw_word(kind);
      n = '0;
      for (int i = 0; i < KW_CHARS; i++) begin
         if (w[8 * (7 - i) +: 8] != 8'h00) begin
            n = n + 4'd1;
         end
      end
      return n;
   endfunction

endpackage

@@ design/blt_if.sv @@
// ----------------------------------------------------------------------------
// blt_if: channel interfaces of the BASIC line tokenizer
// blt_byte_if carries source bytes, blt_token_if carries result items.
// ----------------------------------------------------------------------------
interface blt_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;

   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

interface blt_token_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [31:0] number_value;
   logic [7:0]  text_char;
   logic        text_valid;
   logic        token_end;
   logic        last;

   modport source (output valid, output token_kind, output number_value,
                   output text_char, output text_valid, output token_end,
                   output last, input ready);
   modport sink (input valid, input token_kind, input number_value,
                 input text_char, input text_valid, input token_end,
                 input last, output ready);
endinterface

@@ design/blt_front.sv @@
// ----------------------------------------------------------------------------
// blt_front: source byte classifier
// Sorts each incoming byte into its character classes and works out what
// the byte yields when it arrives between tokens.
// ----------------------------------------------------------------------------
module blt_front (
   input  logic [7:0]            source_byte,
   output blt_pkg::blt_class_type cls
);

   logic                         is_upper;
   logic                         is_lower;
   logic                         is_blank;
   logic                         op_hit;
   logic [blt_pkg::KIND_W-1:0]   op_kind;

   always_comb begin
      op_hit  = 1'b1;
      op_kind = blt_pkg::KIND_END;
      unique case (source_byte)
         "+":     op_kind = blt_pkg::KIND_PLUS;
         "-":     op_kind = blt_pkg::KIND_MINUS;
         "*":     op_kind = blt_pkg::KIND_STAR;
         "/":     op_kind = blt_pkg::KIND_SLASH;
         "(":     op_kind = blt_pkg::KIND_LPAREN;
         ")":     op_kind = blt_pkg::KIND_RPAREN;
         ",":     op_kind = blt_pkg::KIND_COMMA;
         ";":     op_kind = blt_pkg::KIND_SEMI;
         "=":     op_kind = blt_pkg::KIND_EQUAL;
         default: op_hit = 1'b0;
      endcase
   end

   always_comb begin
      is_upper = (source_byte >= "A") && (source_byte <= "Z");
      is_lower = (source_byte >= "a") && (source_byte <= "z");
      is_blank = (source_byte == " ") || (source_byte == blt_pkg::CH_TAB);

      cls.byte_val  = source_byte;
      cls.upper     = is_lower ? (source_byte - 8'd32) : source_byte;
      cls.digit     = source_byte[3:0];
      cls.is_digit  = (source_byte >= "0") && (source_byte <= "9");
      cls.is_alpha  = is_upper || is_lower;
      cls.is_identc = cls.is_alpha || cls.is_digit ||
                      (source_byte == "_") || (source_byte == "$");
      cls.is_quote  = source_byte == blt_pkg::CH_QUOTE;
      cls.is_eol    = (source_byte == blt_pkg::CH_NUL) ||
                      (source_byte == blt_pkg::CH_LF);
      cls.is_lt     = source_byte == "<";
      cls.is_gt     = source_byte == ">";
      cls.is_eq     = source_byte == "=";
      // Between tokens, line ends, operators and unknown bytes each give
      // one result; everything else only opens or skips.
      cls.idle_emit = !(is_blank || cls.is_digit || cls.is_quote || cls.is_alpha ||
                        cls.is_lt || cls.is_gt);
      cls.idle_kind = op_hit ? op_kind : blt_pkg::KIND_END;
   end

endmodule

@@ design/blt_queue.sv @@
// ----------------------------------------------------------------------------
// blt_queue: short queue of classified bytes
// Decouples the classifier from the token sequencer.
// ----------------------------------------------------------------------------
module blt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  blt_pkg::blt_class_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output blt_pkg::blt_class_type head
);

   blt_pkg::blt_class_type            slot_ff [blt_pkg::QUEUE_DEPTH];
   logic [blt_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [blt_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [blt_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [blt_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [blt_pkg::QCOUNT_W-1:0]      count_ff;
   logic [blt_pkg::QCOUNT_W-1:0]      count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full       = count_ff == blt_pkg::QCOUNT_W'(blt_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == blt_pkg::QPTR_W'(blt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == blt_pkg::QPTR_W'(blt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/blt_back.sv @@
// ----------------------------------------------------------------------------
// blt_back: token sequencer
// Runs the scanning state on classified bytes and drives the result
// register, streaming identifier text from the identifier buffer.
// ----------------------------------------------------------------------------
module blt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  blt_pkg::blt_class_type  head,
   output logic                    pop,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output blt_pkg::blt_result_type rsp_item
);

   localparam logic [1:0] S_RUN    = 2'd0;
   localparam logic [1:0] S_FLUSH  = 2'd1;
   localparam logic [1:0] S_SECOND = 2'd2;

   localparam logic [2:0] MODE_IDLE        = 3'd0;
   localparam logic [2:0] MODE_NUMBER      = 3'd1;
   localparam logic [2:0] MODE_IDENT       = 3'd2;
   localparam logic [2:0] MODE_STRING      = 3'd3;
   localparam logic [2:0] MODE_STRING_FULL = 3'd4;
   localparam logic [2:0] MODE_LESS        = 3'd5;
   localparam logic [2:0] MODE_GREATER     = 3'd6;

   localparam int LW = blt_pkg::IDENT_LEN_W;
   localparam int IW = blt_pkg::IDENT_IDX_W;
   localparam int SW = blt_pkg::STR_LEN_W;
   localparam int KC = blt_pkg::KEYWORD_COUNT;

   logic [1:0]                state_ff, state_in;
   logic [2:0]                mode_ff, mode_in;
   logic [31:0]               acc_ff, acc_in;
   logic [LW-1:0]             ilen_ff, ilen_in;
   logic [KC-1:0]             cand_ff, cand_in;
   logic [SW-1:0]             slen_ff, slen_in;
   logic [IW-1:0]             fidx_ff, fidx_in;
   blt_pkg::blt_class_type    held_ff, held_in;
   logic                      redo_ff, redo_in;
   logic                      out_valid_ff, out_valid_in;
   blt_pkg::blt_result_type   out_ff;
   logic [7:0]                ibuf_ff [blt_pkg::MAX_IDENT_CHARS];

   blt_pkg::blt_class_type    act;
   logic                      can_emit;
   logic                      emit;
   blt_pkg::blt_result_type   res;
   logic                      do_idle;
   logic                      first;
   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic [7:0]                wr_data;
   logic [LW-1:0]             nlen;
   logic [KC-1:0]             ncand;
   logic [KC-1:0]             cand_init;
   logic [6:0]                kw_cur;
   logic [6:0]                kw_app;
   logic [2:0]                idle_mode;
   logic                      flush_end;
   logic [31:0]               acc_next;

   function automatic blt_pkg::blt_result_type mk(
      input logic [blt_pkg::KIND_W-1:0] kind,
      input logic [31:0]                value,
      input logic [7:0]                 ch,
      input logic                       valid,
      input logic                       end_flag,
      input logic                       last_flag);
      blt_pkg::blt_result_type r;
      r.token_kind   = kind;
      r.number_value = value;
      r.text_char    = valid ? ch : 8'h00;
      r.text_valid   = valid;
      r.token_end    = end_flag;
      r.last         = last_flag;
      return r;
   endfunction

   // Bit 6 flags a keyword hit, the low bits give its kind.
   function automatic logic [6:0] kw_find(input logic [LW-1:0] len,
                                          input logic [KC-1:0] cnd);
      logic [6:0]                       r;
      logic [blt_pkg::KIND_W-1:0]       kind;
      r = '0;
      for (int k = 0; k < KC; k++) begin
         kind = blt_pkg::KIND_W'(int'(blt_pkg::KIND_LET) + k);
         if (cnd[k] && (int'(len) < blt_pkg::KW_CHARS) &&
             (int'(len) == int'(blt_pkg::kw_len(kind)))) begin
            r = {1'b1, kind};
         end
      end
      return r;
   endfunction

   assign can_emit  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      act      = (state_ff == S_RUN) ? head : held_ff;
      nlen     = ilen_ff + LW'(1);
      acc_next = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + 32'(head.digit);
      // Keyword candidates narrow one character at a time as the name grows.
      for (int k = 0; k < KC; k++) begin
         ncand[k] = cand_ff[k] &&
                    (blt_pkg::kw_char(blt_pkg::KIND_W'(int'(blt_pkg::KIND_LET) + k),
                                      ilen_ff[2:0]) == head.upper);
         cand_init[k] = blt_pkg::kw_char(blt_pkg::KIND_W'(int'(blt_pkg::KIND_LET) + k),
                                         3'd0) == act.upper;
      end
      kw_cur = kw_find(ilen_ff, cand_ff);
      kw_app = kw_find(nlen, ncand);

      priority if (act.is_digit) begin
         idle_mode = MODE_NUMBER;
      end else if (act.is_quote) begin
         idle_mode = MODE_STRING;
      end else if (act.is_alpha) begin
         idle_mode = MODE_IDENT;
      end else if (act.is_lt) begin
         idle_mode = MODE_LESS;
      end else if (act.is_gt) begin
         idle_mode = MODE_GREATER;
      end else begin
         idle_mode = MODE_IDLE;
      end
   end

   assign flush_end = (LW'(fidx_ff) + LW'(1)) == ilen_ff;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      ilen_in  = ilen_ff;
      cand_in  = cand_ff;
      slen_in  = slen_ff;
      fidx_in  = fidx_ff;
      held_in  = held_ff;
      redo_in  = redo_ff;
      wr_en    = 1'b0;
      wr_addr  = ilen_ff[IW-1:0];
      wr_data  = head.upper;
      pop      = 1'b0;
      emit     = 1'b0;
      res      = '0;
      do_idle  = 1'b0;
      first    = 1'b0;

      unique case (state_ff)
         S_RUN: begin
            if (head_valid && can_emit) begin
               pop = 1'b1;
               unique case (mode_ff)
                  MODE_NUMBER: begin
                     if (head.is_digit) begin
                        acc_in = acc_next;
                     end else begin
                        emit    = 1'b1;
                        res     = mk(blt_pkg::KIND_NUMBER, acc_ff, 8'h00, 1'b0, 1'b1,
                                     !head.idle_emit);
                        first   = 1'b1;
                        do_idle = 1'b1;
                     end
                  end
                  MODE_IDENT: begin
                     mode_in = MODE_IDLE;
                     ilen_in = '0;
                     if (head.is_identc) begin
                        wr_en = 1'b1;
                        if (nlen == LW'(blt_pkg::MAX_IDENT_CHARS)) begin
                           // The name is full and completes on this byte.
                           if (kw_app[6]) begin
                              emit = 1'b1;
                              res  = mk(kw_app[5:0], 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
                           end else begin
                              state_in = S_FLUSH;
                              ilen_in  = nlen;
                              fidx_in  = '0;
                              redo_in  = 1'b0;
                              held_in  = head;
                           end
                        end else begin
                           mode_in = MODE_IDENT;
                           ilen_in = nlen;
                           cand_in = ncand;
                        end
                     end else if (kw_cur[6]) begin
                        emit    = 1'b1;
                        res     = mk(kw_cur[5:0], 32'd0, 8'h00, 1'b0, 1'b1,
                                     !head.idle_emit);
                        first   = 1'b1;
                        do_idle = 1'b1;
                     end else begin
                        // The byte that ended the name is handled after the text.
                        state_in = S_FLUSH;
                        ilen_in  = ilen_ff;
                        fidx_in  = '0;
                        redo_in  = 1'b1;
                        held_in  = head;
                     end
                  end
                  MODE_STRING: begin
                     emit = 1'b1;
                     if (head.is_quote) begin
                        res     = mk(blt_pkg::KIND_STRING, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
                        mode_in = MODE_IDLE;
                        slen_in = '0;
                     end else if (head.is_eol) begin
                        res     = mk(blt_pkg::KIND_STRING, 32'd0, 8'h00, 1'b0, 1'b1,
                                     !head.idle_emit);
                        slen_in = '0;
                        first   = 1'b1;
                        do_idle = 1'b1;
                     end else begin
                        res     = mk(blt_pkg::KIND_STRING, 32'd0, head.byte_val, 1'b1,
                                     1'b0, 1'b1);
                        slen_in = slen_ff + SW'(1);
                        if (slen_ff == SW'(blt_pkg::MAX_STRING_CHARS - 1)) begin
                           mode_in = MODE_STRING_FULL;
                        end
                     end
                  end
                  MODE_STRING_FULL: begin
                     emit    = 1'b1;
                     slen_in = '0;
                     mode_in = MODE_IDLE;
                     if (head.is_quote) begin
                        res = mk(blt_pkg::KIND_STRING, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
                     end else begin
                        res     = mk(blt_pkg::KIND_STRING, 32'd0, 8'h00, 1'b0, 1'b1,
                                     !head.idle_emit);
                        first   = 1'b1;
                        do_idle = 1'b1;
                     end
                  end
                  MODE_LESS: begin
                     emit    = 1'b1;
                     mode_in = MODE_IDLE;
                     if (head.is_eq) begin
                        res = mk(blt_pkg::KIND_LE, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
                     end else if (head.is_gt) begin
                        res = mk(blt_pkg::KIND_NE, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
                     end else begin
                        res     = mk(blt_pkg::KIND_LT, 32'd0, 8'h00, 1'b0, 1'b1,
                                     !head.idle_emit);
                        first   = 1'b1;
                        do_idle = 1'b1;
                     end
                  end
                  MODE_GREATER: begin
                     emit    = 1'b1;
                     mode_in = MODE_IDLE;
                     if (head.is_eq) begin
                        res = mk(blt_pkg::KIND_GE, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
                     end else begin
                        res     = mk(blt_pkg::KIND_GT, 32'd0, 8'h00, 1'b0, 1'b1,
                                     !head.idle_emit);
                        first   = 1'b1;
                        do_idle = 1'b1;
                     end
                  end
                  default: begin
                     do_idle = 1'b1;
                  end
               endcase
            end
         end
         S_FLUSH: begin
            if (can_emit) begin
               emit    = 1'b1;
               res     = mk(blt_pkg::KIND_IDENT, 32'd0, ibuf_ff[fidx_ff], 1'b1, flush_end,
                            flush_end && !(redo_ff && held_ff.idle_emit));
               fidx_in = fidx_ff + IW'(1);
               if (flush_end) begin
                  state_in = S_RUN;
                  mode_in  = MODE_IDLE;
                  ilen_in  = '0;
                  if (redo_ff) begin
                     first   = 1'b1;
                     do_idle = 1'b1;
                  end
               end
            end
         end
         S_SECOND: begin
            if (can_emit) begin
               emit     = 1'b1;
               res      = mk(held_ff.idle_kind, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase

      // The byte seen between tokens: open a new token, skip it, or emit.
      if (do_idle) begin
         mode_in = idle_mode;
         if (act.is_digit) begin
            acc_in = 32'(act.digit);
         end
         if (act.is_quote) begin
            slen_in = '0;
         end
         if (act.is_alpha) begin
            ilen_in = LW'(1);
            cand_in = cand_init;
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = act.upper;
         end
         if (act.idle_emit) begin
            if (first) begin
               state_in = S_SECOND;
               held_in  = act;
            end else begin
               emit = 1'b1;
               res  = mk(act.idle_kind, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1);
            end
         end
      end

      out_valid_in = emit || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         mode_ff      <= MODE_IDLE;
         ilen_ff      <= '0;
         slen_ff      <= '0;
         fidx_ff      <= '0;
         redo_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         ilen_ff      <= ilen_in;
         slen_ff      <= slen_in;
         fidx_ff      <= fidx_in;
         redo_ff      <= redo_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      cand_ff <= cand_in;
      held_ff <= held_in;
      if (emit) begin
         out_ff <= res;
      end
      if (wr_en) begin
         ibuf_ff[wr_addr] <= wr_data;
      end
   end

endmodule

@@ design/basic_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// basic_line_tokenizer_core: BASIC line tokenizer
// Takes one source byte per item and emits number, string, identifier,
// keyword, operator and end tokens as result items.
//
//   channel  dir  interface     payload
//   req_bus  in   blt_byte_if   source_byte
//   rsp_bus  out  blt_token_if  token_kind, number_value, text_char,
//                               text_valid, token_end, last
//
// The token sequencer writes one result per cycle into its output register
// while the output is not stalled. A byte that ends one token and emits
// another gives its second result from the S_SECOND state. While a plain
// identifier's text streams from the identifier buffer, the byte that ended
// it is held, and any token of its own follows the text.
// Reset is synchronous.
// A four-entry queue between classifier and sequencer absorbs output stalls.
// ----------------------------------------------------------------------------
module basic_line_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   blt_byte_if.sink    req_bus,
   blt_token_if.source rsp_bus
);

   blt_pkg::blt_class_type  in_cls;
   blt_pkg::blt_class_type  head;
   blt_pkg::blt_result_type item;
   logic                    full;
   logic                    head_valid;
   logic                    pop;
   logic                    out_valid;

   blt_front u_front (
      .source_byte (req_bus.source_byte),
      .cls         (in_cls)
   );

   blt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_bus.valid),
      .push_item  (in_cls),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   blt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (out_valid),
      .rsp_item   (item)
   );

   assign req_bus.ready        = !full;
   assign rsp_bus.valid        = out_valid;
   assign rsp_bus.token_kind   = item.token_kind;
   assign rsp_bus.number_value = item.number_value;
   assign rsp_bus.text_char    = item.text_char;
   assign rsp_bus.text_valid   = item.text_valid;
   assign rsp_bus.token_end    = item.token_end;
   assign rsp_bus.last         = item.last;

endmodule

@@ verif/basic_line_tokenizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// basic_line_tokenizer_core_tb: self-checking bench of the BASIC line tokenizer
// Streams source bytes into the tokenizer and predicts every token it emits.
// A directed part covers the corner cases. Random BASIC-like lines with noise
// follow, while the sender works in bursts and the receiver stalls on
// patterns of its own. Each result item is checked field by field.
// ----------------------------------------------------------------------------
module basic_line_tokenizer_core_tb;
   import blt_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 136;
   localparam int TAIL_CYCLES   = 60;

   typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_HOLD} rx_pattern_e;

   class token_scoreboard;
      typedef enum logic [2:0] {
         SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_STRING, SCAN_STRING_FULL,
         SCAN_LESS, SCAN_GREATER
      } scan_state_e;

      scan_state_e    scan;
      logic [31:0]    accum;
      logic [7:0]     ident_text [MAX_IDENT_CHARS];
      int             ident_len;
      int             string_len;
      int             errors;
      string          keywords [KEYWORD_COUNT];
      blt_result_type expected_tokens [$];
      blt_result_type byte_tokens [$];

      function new();
         scan       = SCAN_IDLE;
         accum      = '0;
         ident_len  = 0;
         string_len = 0;
         errors     = 0;
         keywords   = '{"LET", "PRINT", "INPUT", "IF", "THEN", "GOTO", "GOSUB",
                        "RETURN", "FOR", "TO", "STEP", "NEXT", "REM", "END",
                        "CLS", "CIRCLE", "WAIT", "PRESENT"};
      endfunction

      function automatic bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function automatic bit is_alpha(logic [7:0] b);
         return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
      endfunction

      function void emit(logic [KIND_W-1:0] kind, logic [31:0] value,
                         logic [7:0] ch, logic has_char, logic ends);
         blt_result_type r;
         r.token_kind   = kind;
         r.number_value = value;
         r.text_char    = has_char ? ch : 8'h00;
         r.text_valid   = has_char;
         r.token_end    = ends;
         r.last         = 1'b0;
         byte_tokens.push_back(r);
      endfunction

      // A finished identifier is either one keyword token or its own text.
      function void flush_ident();
         int hit;
         bit same;
         hit = -1;
         for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (hit < 0 && keywords[k].len() == ident_len) begin
               same = 1'b1;
               for (int i = 0; i < ident_len; i++) begin
                  if (ident_text[i] != keywords[k][i]) same = 1'b0;
               end
               if (same) hit = k;
            end
         end
         if (hit >= 0) begin
            emit(KIND_W'(int'(KIND_LET) + hit), '0, '0, 1'b0, 1'b1);
         end else begin
            for (int i = 0; i < ident_len; i++) begin
               emit(KIND_IDENT, '0, ident_text[i], 1'b1, i == ident_len - 1);
            end
         end
         ident_len = 0;
         scan      = SCAN_IDLE;
      endfunction

      function void append_ident(logic [7:0] b);
         if (b >= "a" && b <= "z") b = b - 8'd32;
         if (ident_len < MAX_IDENT_CHARS) begin
            ident_text[ident_len] = b;
            ident_len = ident_len + 1;
         end
         if (ident_len >= MAX_IDENT_CHARS) flush_ident();
      endfunction

      // Returns 1 when the byte has to be looked at again from idle.
      function bit scan_byte(logic [7:0] b);
         case (scan)
            SCAN_NUMBER: begin
               if (is_digit(b)) begin
                  accum = accum * 32'd10 + {24'h0, b - 8'h30};
                  return 1'b0;
               end
               emit(KIND_NUMBER, accum, '0, 1'b0, 1'b1);
               accum = '0;
               scan  = SCAN_IDLE;
               return 1'b1;
            end
            SCAN_IDENT: begin
               if (is_alpha(b) || is_digit(b) || b == "_" || b == "$") begin
                  append_ident(b);
                  return 1'b0;
               end
               flush_ident();
               return 1'b1;
            end
            SCAN_STRING: begin
               if (b == CH_QUOTE || b == CH_NUL || b == CH_LF) begin
                  emit(KIND_STRING, '0, '0, 1'b0, 1'b1);
                  string_len = 0;
                  scan       = SCAN_IDLE;
                  return b != CH_QUOTE;
               end
               emit(KIND_STRING, '0, b, 1'b1, 1'b0);
               string_len = string_len + 1;
               if (string_len >= MAX_STRING_CHARS) scan = SCAN_STRING_FULL;
               return 1'b0;
            end
            SCAN_STRING_FULL: begin
               emit(KIND_STRING, '0, '0, 1'b0, 1'b1);
               string_len = 0;
               scan       = SCAN_IDLE;
               return b != CH_QUOTE;
            end
            SCAN_LESS: begin
               scan = SCAN_IDLE;
               if (b == "=") begin
                  emit(KIND_LE, '0, '0, 1'b0, 1'b1);
                  return 1'b0;
               end
               if (b == ">") begin
                  emit(KIND_NE, '0, '0, 1'b0, 1'b1);
                  return 1'b0;
               end
               emit(KIND_LT, '0, '0, 1'b0, 1'b1);
               return 1'b1;
            end
            SCAN_GREATER: begin
               scan = SCAN_IDLE;
               if (b == "=") begin
                  emit(KIND_GE, '0, '0, 1'b0, 1'b1);
                  return 1'b0;
               end
               emit(KIND_GT, '0, '0, 1'b0, 1'b1);
               return 1'b1;
            end
            default: ;
         endcase

         scan = SCAN_IDLE;
         case (b)
            " ", CH_TAB: ;
            CH_NUL, CH_LF: emit(KIND_END, '0, '0, 1'b0, 1'b1);
            CH_QUOTE: begin
               string_len = 0;
               scan       = SCAN_STRING;
            end
            "<": scan = SCAN_LESS;
            ">": scan = SCAN_GREATER;
            "+": emit(KIND_PLUS, '0, '0, 1'b0, 1'b1);
            "-": emit(KIND_MINUS, '0, '0, 1'b0, 1'b1);
            "*": emit(KIND_STAR, '0, '0, 1'b0, 1'b1);
            "/": emit(KIND_SLASH, '0, '0, 1'b0, 1'b1);
            "(": emit(KIND_LPAREN, '0, '0, 1'b0, 1'b1);
            ")": emit(KIND_RPAREN, '0, '0, 1'b0, 1'b1);
            ",": emit(KIND_COMMA, '0, '0, 1'b0, 1'b1);
            ";": emit(KIND_SEMI, '0, '0, 1'b0, 1'b1);
            "=": emit(KIND_EQUAL, '0, '0, 1'b0, 1'b1);
            default: begin
               if (is_digit(b)) begin
                  accum = {24'h0, b - 8'h30};
                  scan  = SCAN_NUMBER;
               end else if (is_alpha(b)) begin
                  ident_len = 0;
                  scan      = SCAN_IDENT;
                  append_ident(b);
               end else begin
                  emit(KIND_END, '0, '0, 1'b0, 1'b1);
               end
            end
         endcase
         return 1'b0;
      endfunction

      function void note_byte(logic [7:0] b);
         byte_tokens.delete();
         if (scan_byte(b)) void'(scan_byte(b));
         if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
         foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, seen);
         end
      endfunction

      function void check_token(blt_result_type seen);
         blt_result_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: result item with none expected, expected nothing, actual %p",
                     $time, seen);
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_kind", want.token_kind, seen.token_kind);
         compare_field("number_value", want.number_value, seen.number_value);
         compare_field("text_char", want.text_char, seen.text_char);
         compare_field("text_valid", want.text_valid, seen.text_valid);
         compare_field("token_end", want.token_end, seen.token_end);
         compare_field("last", want.last, seen.last);
      endfunction
   endclass

   logic clock;
   logic reset;

   blt_byte_if  req_bus ();
   blt_token_if rsp_bus ();

   basic_line_tokenizer_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   token_scoreboard sb = new();
   int              burst_left = 0;
   int              bytes_sent = 0;
   int              quiet_cycles = 0;
   string           ident_chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_$";
   string           operators [14] = '{"+", "-", "*", "/", "(", ")", ",", ";", "=",
                                       "<", "<=", "<>", ">", ">="};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: free flow, choppy acceptance, or a long hold, in runs.
   initial begin
      rx_pattern_e pattern;
      int          run_left;
      pattern  = RX_FLOW;
      run_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            pattern  = rx_pattern_e'($urandom_range(0, 2));
            run_left = (pattern == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(5, 80);
         end
         run_left--;
         case (pattern)
            RX_FLOW:   rsp_bus.ready = 1'b1;
            RX_CHOPPY: rsp_bus.ready = ($urandom_range(0, 9) < 6);
            default:   rsp_bus.ready = 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      blt_result_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.token_kind   = rsp_bus.token_kind;
         seen.number_value = rsp_bus.number_value;
         seen.text_char    = rsp_bus.text_char;
         seen.text_valid   = rsp_bus.text_valid;
         seen.token_end    = rsp_bus.token_end;
         seen.last         = rsp_bus.last;
         sb.check_token(seen);
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("basic_line_tokenizer_core_tb failed");
         $finish;
      end
   end

   // The sender works in bursts; a gap opens whenever the burst runs out.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_bus.valid       = 1'b1;
      req_bus.source_byte = b;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(b);
      bytes_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      burst_left    = 0;
      while (sb.expected_tokens.size() != 0) @(negedge clock);
   endtask

   // A string body byte: anything but a quote or a line end.
   function automatic logic [7:0] string_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_LF);
      return b;
   endfunction

   task automatic send_random_line();
      int    tokens;
      int    len;
      int    pick;
      string word;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: begin
               word = sb.keywords[$urandom_range(0, KEYWORD_COUNT - 1)];
               for (int i = 0; i < word.len(); i++) begin
                  send_byte($urandom_range(0, 1) ? word[i] : word[i] + 8'd32);
               end
            end
            2: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 34) : $urandom_range(1, 6);
               send_byte(ident_chars[$urandom_range(0, 51)]);
               for (int i = 1; i < len; i++) begin
                  send_byte(ident_chars[$urandom_range(0, ident_chars.len() - 1)]);
               end
            end
            3: begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
               repeat (len) send_byte(8'("0" + $urandom_range(0, 9)));
            end
            4: begin
               send_byte(CH_QUOTE);
               repeat ($urandom_range(0, 8)) begin
                  send_byte(($urandom_range(0, 3) == 0) ? string_byte()
                                                        : 8'($urandom_range(8'h23, 8'h7E)));
               end
               // Now and then the line end closes the string instead.
               if ($urandom_range(0, 5) == 0) break;
               send_byte(CH_QUOTE);
            end
            5, 6, 7: send_text(operators[$urandom_range(0, 13)]);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 3) != 0) send_byte($urandom_range(0, 4) == 0 ? CH_TAB : " ");
      end
      send_byte($urandom_range(0, 1) ? CH_LF : CH_NUL);
   endtask

   initial begin
      int random_goal;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.source_byte = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Keyword, identifier, wrapping number, strings, all operator pairs
      // including a blank inside one, unknown bytes and both line ends.
      send_text("IF a_1$<=4294967296 THEN\"Hi\"<>< =>=>;?_");
      send_byte(8'hFF);
      send_byte(CH_NUL);
      send_text("\"ab");
      send_byte(CH_LF);
      // An identifier at the length limit, then a stray underscore.
      send_text("ABCDEFGHIJKLMNOPQRSTUVWXYZabcde_presentx present");
      send_byte(CH_LF);
      // Let every expected result come out before the random part starts.
      wait_drained();

      random_goal = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < random_goal) begin
         send_random_line();
         if (bytes_sent >= random_goal - RANDOM_ITEMS / 2 && burst_left > 0 &&
             $urandom_range(0, 2) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
         $display("basic_line_tokenizer_core_tb passed");
      end else begin
         $display("basic_line_tokenizer_core_tb failed");
      end
      $finish;
   end

endmodule
